// ===== rtl/kvbs_pkg.sv =====
// ----------------------------------------------------------------------------
// kvbs_pkg
// Types and codes shared by the key/value bucket sorter.
// ----------------------------------------------------------------------------
package kvbs_pkg;

  localparam int unsigned WORD_W = 64;

  // Actions carried in an input beat.
  localparam logic [1:0] ACT_APPEND = 2'd0;
  localparam logic [1:0] ACT_WRITE  = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;
  localparam logic [1:0] ACT_SORT   = 2'd3;

  // Result status codes.
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_KEY_WORDS   = 2'd0;
  localparam logic [1:0] CFG_VALUE_WORDS = 2'd1;
  localparam logic [1:0] CFG_TUPLE_LIMIT = 2'd2;

  typedef struct packed {
    logic [1:0]        action;
    logic [6:0]        position;
    logic [WORD_W-1:0] key_word_0;
    logic [WORD_W-1:0] key_word_1;
    logic [WORD_W-1:0] key_word_2;
    logic [WORD_W-1:0] key_word_3;
    logic [WORD_W-1:0] value_word_0;
    logic [WORD_W-1:0] value_word_1;
    logic [WORD_W-1:0] value_word_2;
    logic [WORD_W-1:0] value_word_3;
  } in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [7:0]        tuple_total;
    logic [WORD_W-1:0] read_key_0;
    logic [WORD_W-1:0] read_key_1;
    logic [WORD_W-1:0] read_key_2;
    logic [WORD_W-1:0] read_key_3;
    logic [WORD_W-1:0] read_value_0;
    logic [WORD_W-1:0] read_value_1;
    logic [WORD_W-1:0] read_value_2;
    logic [WORD_W-1:0] read_value_3;
  } out_t;

endpackage

// ===== rtl/kvbs_store.sv =====
// ----------------------------------------------------------------------------
// kvbs_store
// Tuple store: one key row and one value row per slot, one write port with
// per-word enables and one read port with a registered read.
// ----------------------------------------------------------------------------
module kvbs_store #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned KN    = 4,
  parameter int unsigned VN    = 4
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [$clog2(DEPTH)-1:0]              waddr_i,
  input  logic [KN-1:0]                         kmask_i,
  input  logic [KN-1:0][kvbs_pkg::WORD_W-1:0]   kdata_i,
  input  logic [VN-1:0]                         vmask_i,
  input  logic [VN-1:0][kvbs_pkg::WORD_W-1:0]   vdata_i,
  input  logic                                  re_i,
  input  logic [$clog2(DEPTH)-1:0]              raddr_i,
  output logic [KN-1:0][kvbs_pkg::WORD_W-1:0]   rkey_o,
  output logic [VN-1:0][kvbs_pkg::WORD_W-1:0]   rval_o
);
  import kvbs_pkg::*;

  logic [KN-1:0][WORD_W-1:0] kmem [DEPTH];
  logic [VN-1:0][WORD_W-1:0] vmem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      for (int w = 0; w < KN; w++) begin
        if (kmask_i[w]) begin
          kmem[waddr_i][w] <= kdata_i[w];
        end
      end
      for (int w = 0; w < VN; w++) begin
        if (vmask_i[w]) begin
          vmem[waddr_i][w] <= vdata_i[w];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rkey_o <= kmem[raddr_i];
      rval_o <= vmem[raddr_i];
    end
  end

endmodule

// ===== rtl/key_value_bucket_sorter_unit.sv =====
// ----------------------------------------------------------------------------
// key_value_bucket_sorter_unit
// Fixed-capacity bucket of key/value tuples with a stable lexicographic sort.
// ----------------------------------------------------------------------------
// After reset the block clears its store slot by slot and takes no beat
// meanwhile. Append and write finish in the idle state; a read waits for
// the registered store read in ST_READ. Sort is an insertion sort over the
// store: each tuple is loaded, each larger tuple is shifted up one slot and
// the tuple is written into the gap. One beat is worked on at a time.
module key_value_bucket_sorter_unit #(
  parameter int unsigned SLOT_COUNT      = 128,
  parameter int unsigned MAX_KEY_WORDS   = 4,
  parameter int unsigned MAX_VALUE_WORDS = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [7:0]      cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  kvbs_pkg::in_t   in_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output kvbs_pkg::out_t  out_o
);
  import kvbs_pkg::*;

  localparam int unsigned AW    = $clog2(SLOT_COUNT);
  localparam int unsigned CNT_W = $clog2(SLOT_COUNT + 1);
  localparam int unsigned LW    = (CNT_W > 8) ? CNT_W : 8;
  localparam int unsigned KN    = MAX_KEY_WORDS;
  localparam int unsigned VN    = MAX_VALUE_WORDS;
  localparam int unsigned KIW   = (KN > 1) ? $clog2(KN) : 1;
  localparam int unsigned VIW   = (VN > 1) ? $clog2(VN) : 1;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_HOLD  = 3'd3;
  localparam logic [2:0] ST_CMP   = 3'd4;
  localparam logic [2:0] ST_PLACE = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [2:0]       key_words_q, value_words_q;
  logic [7:0]       tuple_limit_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic [AW-1:0]    clr_q, clr_d;
  logic [AW-1:0]    i_q, i_d;
  logic [AW-1:0]    j_q, j_d;
  logic             out_valid_q, out_valid_d;
  out_t             out_q, out_d;
  logic [KN-1:0][WORD_W-1:0] t_key_q, t_key_d;
  logic [VN-1:0][WORD_W-1:0] t_val_q, t_val_d;

  // Store ports.
  logic                      we, re;
  logic [AW-1:0]             waddr, raddr;
  logic [KN-1:0]             kmask;
  logic [VN-1:0]             vmask;
  logic [KN-1:0][WORD_W-1:0] kdata, rkey;
  logic [VN-1:0][WORD_W-1:0] vdata, rval;

  logic [3:0]      kw, vw, kwx, vwx;
  logic [LW-1:0]   lim, tl, pos_x;
  logic [KN-1:0]   kuse;
  logic [VN-1:0]   vuse;
  logic [3:0][WORD_W-1:0] in_key, in_val;
  logic [KN-1:0][WORD_W-1:0] in_kw;
  logic [VN-1:0][WORD_W-1:0] in_vw;
  logic            accept, out_free, greater, last_i;

  // Effective configuration.
  always_comb begin
    kwx = {1'b0, key_words_q};
    vwx = {1'b0, value_words_q};
    kw  = (kwx == 4'd0) ? 4'd1 : ((kwx > 4'(KN)) ? 4'(KN) : kwx);
    vw  = (vwx == 4'd0) ? 4'd1 : ((vwx > 4'(VN)) ? 4'(VN) : vwx);
    tl  = LW'(tuple_limit_q);
    lim = (tl == '0) ? LW'(1) : ((tl > LW'(SLOT_COUNT)) ? LW'(SLOT_COUNT) : tl);
    pos_x = LW'(in_i.position);
    for (int w = 0; w < KN; w++) kuse[w] = (4'(w) < kw);
    for (int w = 0; w < VN; w++) vuse[w] = (4'(w) < vw);
    in_key = {in_i.key_word_3, in_i.key_word_2, in_i.key_word_1, in_i.key_word_0};
    in_val = {in_i.value_word_3, in_i.value_word_2, in_i.value_word_1,
              in_i.value_word_0};
    for (int w = 0; w < KN; w++) in_kw[w] = (w < 4) ? in_key[2'(w)] : '0;
    for (int w = 0; w < VN; w++) in_vw[w] = (w < 4) ? in_val[2'(w)] : '0;
  end

  // Strictly greater over the first kw words, word 0 most significant.
  always_comb begin
    logic decided;
    decided = 1'b0;
    greater = 1'b0;
    for (int w = 0; w < KN; w++) begin
      if (!decided && kuse[w]) begin
        if (rkey[w] > t_key_q[w]) begin
          greater = 1'b1;
          decided = 1'b1;
        end else if (rkey[w] < t_key_q[w]) begin
          decided = 1'b1;
        end
      end
    end
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !(state_q == ST_IDLE && out_free);
  assign accept     = in_valid_i && !in_stall_o;
  assign last_i     = (CNT_W'(i_q) + CNT_W'(1)) >= count_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    clr_d       = clr_q;
    i_d         = i_q;
    j_d         = j_q;
    t_key_d     = t_key_q;
    t_val_d     = t_val_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    we = 1'b0; re = 1'b0;
    waddr = '0; raddr = '0;
    kmask = '0; vmask = '0;
    kdata = in_kw; vdata = in_vw;

    unique case (state_q) inside
      ST_CLEAR: begin
        we = 1'b1; waddr = clr_q;
        kmask = '1; vmask = '1;
        kdata = '0; vdata = '0;
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(SLOT_COUNT - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          out_d        = '0;
          out_d.status = STAT_OK;
          unique case (in_i.action)
            ACT_APPEND: begin
              if (LW'(count_q) >= lim) begin
                out_d.status = STAT_FULL;
              end else begin
                we = 1'b1; waddr = count_q[AW-1:0];
                kmask = kuse; vmask = vuse;
                count_d = count_q + CNT_W'(1);
              end
              out_valid_d = 1'b1;
            end
            ACT_WRITE: begin
              if (pos_x >= lim) begin
                out_d.status = STAT_RANGE;
              end else begin
                we = 1'b1; waddr = pos_x[AW-1:0];
                kmask = kuse; vmask = vuse;
              end
              out_valid_d = 1'b1;
            end
            ACT_READ: begin
              if (pos_x >= lim) begin
                out_d.status = STAT_RANGE;
                out_valid_d  = 1'b1;
              end else begin
                re = 1'b1; raddr = pos_x[AW-1:0];
                state_d = ST_READ;
              end
            end
            ACT_SORT: begin
              if (count_q < CNT_W'(2)) begin
                out_valid_d = 1'b1;
              end else begin
                re = 1'b1; raddr = AW'(1);
                i_d = AW'(1);
                state_d = ST_HOLD;
              end
            end
            default: ;
          endcase
          out_d.tuple_total = 8'(count_d);
        end
      end
      ST_READ: begin
        out_d.read_key_0   = (KN > 0 && kuse[0]) ? rkey[0] : '0;
        out_d.read_key_1   = (KN > 1 && kw > 4'd1) ? rkey[KIW'(1)] : '0;
        out_d.read_key_2   = (KN > 2 && kw > 4'd2) ? rkey[KIW'(2)] : '0;
        out_d.read_key_3   = (KN > 3 && kw > 4'd3) ? rkey[KIW'(3)] : '0;
        out_d.read_value_0 = (VN > 0 && vuse[0]) ? rval[0] : '0;
        out_d.read_value_1 = (VN > 1 && vw > 4'd1) ? rval[VIW'(1)] : '0;
        out_d.read_value_2 = (VN > 2 && vw > 4'd2) ? rval[VIW'(2)] : '0;
        out_d.read_value_3 = (VN > 3 && vw > 4'd3) ? rval[VIW'(3)] : '0;
        out_valid_d = 1'b1;
        state_d     = ST_IDLE;
      end
      ST_HOLD: begin
        // Slot i is the tuple being inserted; compare it against slot i-1.
        t_key_d = rkey;
        t_val_d = rval;
        re = 1'b1; raddr = i_q - AW'(1);
        j_d = i_q;
        state_d = ST_CMP;
      end
      ST_CMP, ST_PLACE: begin
        we = 1'b1; kmask = '1; vmask = '1;
        if (state_q == ST_CMP && greater) begin
          // Shift the larger tuple up one slot and keep walking down.
          waddr = j_q; kdata = rkey; vdata = rval;
          j_d = j_q - AW'(1);
          if (j_q == AW'(1)) begin
            state_d = ST_PLACE;
          end else begin
            re = 1'b1; raddr = j_q - AW'(2);
          end
        end else begin
          waddr = (state_q == ST_PLACE) ? AW'(0) : j_q;
          kdata = t_key_q; vdata = t_val_q;
          if (last_i) begin
            out_valid_d = 1'b1;
            state_d     = ST_IDLE;
          end else begin
            i_d = i_q + AW'(1);
            re = 1'b1; raddr = i_q + AW'(1);
            state_d = ST_HOLD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      key_words_q   <= 3'd2;
      value_words_q <= 3'd2;
      tuple_limit_q <= 8'd128;
      count_q       <= '0;
      clr_q         <= '0;
      i_q           <= '0;
      j_q           <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      clr_q       <= clr_d;
      i_q         <= i_d;
      j_q         <= j_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_KEY_WORDS:   key_words_q   <= cfg_data_i[2:0];
          CFG_VALUE_WORDS: value_words_q <= cfg_data_i[2:0];
          CFG_TUPLE_LIMIT: tuple_limit_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q   <= out_d;
    t_key_q <= t_key_d;
    t_val_q <= t_val_d;
  end

  kvbs_store #(
    .DEPTH (SLOT_COUNT),
    .KN    (KN),
    .VN    (VN)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .kmask_i (kmask),
    .kdata_i (kdata),
    .vmask_i (vmask),
    .vdata_i (vdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rkey_o  (rkey),
    .rval_o  (rval)
  );

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // The store never reads and writes the same slot in one cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we && re) |-> (waddr != raddr))
    else $error("store read and write collide");

  // A beat is only taken while the sequencer is idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> (state_q == ST_IDLE))
    else $error("beat taken while busy");

  // A read result is valid in the cycle following ST_READ.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |=> out_valid_o)
    else $error("read result missing");

  // The tuple count never passes the store depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(SLOT_COUNT))
    else $error("tuple count overflow");

endmodule
